>>> hw/rtl/l4_probe_header_generator_unit_assert.svh
// Assertion macros used by the port-level checker of the probe header generator.
`ifndef L4_PROBE_HEADER_GENERATOR_UNIT_ASSERT_SVH
`define L4_PROBE_HEADER_GENERATOR_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define L4PHG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("l4phg assertion failed");

// Clocked assertion that is also checked through reset.
`define L4PHG_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("l4phg assertion failed");

`endif

>>> hw/rtl/l4phg_pkg.sv
// Package with the constants and types of the layer-4 probe header generator.
package l4phg_pkg;

   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int WORD_W       = 16;
   localparam int WORD_INDEX_W = 4;
   localparam int PART_W       = 18;
   localparam int TOTAL_W      = 21;

   localparam logic [CSR_INDEX_W-1:0] CSR_FAMILY      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_HIGH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_LOW     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TGT_HIGH    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TGT_LOW     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_PORT  = 3'd5;

   localparam logic KIND_TCP = 1'b0;
   localparam logic KIND_UDP = 1'b1;

   localparam logic FAMILY_IPV4 = 1'b0;

   localparam int PROTO_TCP       = 6;
   localparam int PROTO_UDP       = 17;
   localparam int TCP_LEN         = 20;
   localparam int UDP_LEN         = 8;
   localparam logic [WORD_W-1:0] TCP_FLAGS_WORD = 16'h5002;
   localparam logic [WORD_W-1:0] TCP_WINDOW     = 16'hFFFF;
   localparam logic [WORD_W-1:0] UDP_LEN_WORD   = 16'(UDP_LEN);

   localparam logic [WORD_INDEX_W-1:0] TCP_LAST_INDEX = 4'd9;
   localparam logic [WORD_INDEX_W-1:0] UDP_LAST_INDEX = 4'd3;

   // Word positions of the TCP and UDP headers that hold more than zero.
   localparam logic [WORD_INDEX_W-1:0] POS_SRC_PORT = 4'd0;
   localparam logic [WORD_INDEX_W-1:0] POS_DST_PORT = 4'd1;
   localparam logic [WORD_INDEX_W-1:0] POS_UDP_LEN  = 4'd2;
   localparam logic [WORD_INDEX_W-1:0] POS_UDP_SUM  = 4'd3;
   localparam logic [WORD_INDEX_W-1:0] POS_FLAGS    = 4'd6;
   localparam logic [WORD_INDEX_W-1:0] POS_WINDOW   = 4'd7;
   localparam logic [WORD_INDEX_W-1:0] POS_TCP_SUM  = 4'd8;

   // Fixed part of the sum: protocol, layer-4 length and constant header words.
   localparam logic [PART_W-1:0] HDR_CONST_TCP =
      PART_W'(PROTO_TCP + TCP_LEN + 32'h5002 + 32'hFFFF);
   localparam logic [PART_W-1:0] HDR_CONST_UDP =
      PART_W'(PROTO_UDP + UDP_LEN + UDP_LEN);

   typedef logic [PART_W-1:0] part_type;

endpackage

>>> hw/rtl/l4_probe_header_generator_unit.sv
// A taken request beat passes through stages s1, s2 and s3 into the output serializer,
// which offers one header word per cycle while rsp_tready is high, so a TCP SYN
// probe is ten words and a UDP probe four; the checksum pipeline overlaps the
// header before it. Reset is synchronous and active high: it clears all valid
// flags, the word counter and every configuration register.
module l4_probe_header_generator_unit
   import l4phg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,  // [15:0] remote_port
   input  logic [0:0]             req_tuser,  // [0] action
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,  // [15:0] header_word
   output logic                   rsp_tlast
);

   logic              family_ff;
   logic [63:0]       src_high_ff, src_low_ff, tgt_high_ff, tgt_low_ff;
   logic [WORD_W-1:0] local_port_ff;

   logic              s1_valid_ff, s1_kind_ff;
   logic [WORD_W-1:0] s1_port_ff;
   logic              s2_valid_ff, s2_kind_ff;
   logic [WORD_W-1:0] s2_port_ff;
   part_type          s2_part_ff [4];
   part_type          s2_part_in [4];
   part_type          s2_hdr_ff, s2_hdr_in;
   logic              s3_valid_ff, s3_kind_ff;
   logic [WORD_W-1:0] s3_port_ff;
   logic [TOTAL_W-1:0] s3_total_ff, s3_total_in;

   logic                    out_valid_ff, out_kind_ff;
   logic [WORD_W-1:0]       out_port_ff, out_csum_ff;
   logic [WORD_INDEX_W-1:0] out_index_ff;

   logic              advance, ser_load, rsp_fire, out_last;
   logic [16:0]       fold1, fold2;
   logic [WORD_W-1:0] csum_in;
   logic [63:0]       src_high_m, src_low_m, tgt_high_m, tgt_low_m;

   function automatic part_type sum4(input logic [63:0] v);
      sum4 = PART_W'(v[15:0]) + PART_W'(v[31:16]) + PART_W'(v[47:32]) + PART_W'(v[63:48]);
   endfunction

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         family_ff     <= 1'b0;
         src_high_ff   <= '0;
         src_low_ff    <= '0;
         tgt_high_ff   <= '0;
         tgt_low_ff    <= '0;
         local_port_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FAMILY:     family_ff     <= csr_wdata[0];
            CSR_SRC_HIGH:   src_high_ff   <= csr_wdata;
            CSR_SRC_LOW:    src_low_ff    <= csr_wdata;
            CSR_TGT_HIGH:   tgt_high_ff   <= csr_wdata;
            CSR_TGT_LOW:    tgt_low_ff    <= csr_wdata;
            CSR_LOCAL_PORT: local_port_ff <= csr_wdata[WORD_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_fire   = out_valid_ff && rsp_tready;
   assign out_last   = (out_kind_ff == KIND_UDP) ? (out_index_ff == UDP_LAST_INDEX)
                                                 : (out_index_ff == TCP_LAST_INDEX);
   assign ser_load   = s3_valid_ff && (!out_valid_ff || (rsp_fire && out_last));
   assign advance    = !s3_valid_ff || ser_load;
   assign req_tready = advance;

   // IPv4 uses only the low 32 bits of each low address register.
   always_comb begin
      if (family_ff == FAMILY_IPV4) begin
         src_high_m = '0;
         tgt_high_m = '0;
         src_low_m  = {32'd0, src_low_ff[31:0]};
         tgt_low_m  = {32'd0, tgt_low_ff[31:0]};
      end else begin
         src_high_m = src_high_ff;
         tgt_high_m = tgt_high_ff;
         src_low_m  = src_low_ff;
         tgt_low_m  = tgt_low_ff;
      end
      s2_part_in[0] = sum4(src_high_m);
      s2_part_in[1] = sum4(src_low_m);
      s2_part_in[2] = sum4(tgt_high_m);
      s2_part_in[3] = sum4(tgt_low_m);
      s2_hdr_in = ((s1_kind_ff == KIND_UDP) ? HDR_CONST_UDP : HDR_CONST_TCP)
                  + PART_W'(local_port_ff) + PART_W'(s1_port_ff);
   end

   assign s3_total_in = TOTAL_W'(s2_part_ff[0]) + TOTAL_W'(s2_part_ff[1])
                      + TOTAL_W'(s2_part_ff[2]) + TOTAL_W'(s2_part_ff[3])
                      + TOTAL_W'(s2_hdr_ff);

   // Two folds are enough: after the first the carry is at most one.
   assign fold1   = 17'(s3_total_ff[15:0]) + 17'(s3_total_ff[TOTAL_W-1:16]);
   assign fold2   = 17'(fold1[15:0]) + 17'(fold1[16]);
   assign csum_in = ~fold2[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff  <= req_tuser[0];
         s1_port_ff  <= req_tdata;
         s2_kind_ff  <= s1_kind_ff;
         s2_port_ff  <= s1_port_ff;
         s2_part_ff  <= s2_part_in;
         s2_hdr_ff   <= s2_hdr_in;
         s3_kind_ff  <= s2_kind_ff;
         s3_port_ff  <= s2_port_ff;
         s3_total_ff <= s3_total_in;
      end
   end

   // Output serializer: one header word per beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_index_ff <= '0;
      end else if (ser_load) begin
         out_valid_ff <= 1'b1;
         out_index_ff <= '0;
      end else if (rsp_fire) begin
         if (out_last) begin
            out_valid_ff <= 1'b0;
            out_index_ff <= '0;
         end else begin
            out_index_ff <= out_index_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ser_load) begin
         out_kind_ff <= s3_kind_ff;
         out_port_ff <= s3_port_ff;
         out_csum_ff <= csum_in;
      end
   end

   always_comb begin
      case (out_index_ff)
         POS_SRC_PORT: rsp_tdata = local_port_ff;
         POS_DST_PORT: rsp_tdata = out_port_ff;
         POS_UDP_LEN:  rsp_tdata = (out_kind_ff == KIND_UDP) ? UDP_LEN_WORD : '0;
         POS_UDP_SUM:  rsp_tdata = (out_kind_ff == KIND_UDP) ? out_csum_ff : '0;
         POS_FLAGS:    rsp_tdata = TCP_FLAGS_WORD;
         POS_WINDOW:   rsp_tdata = TCP_WINDOW;
         POS_TCP_SUM:  rsp_tdata = out_csum_ff;
         default:      rsp_tdata = '0;
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last;

endmodule

>>> hw/rtl/l4phg_checker.sv
// Port-level checker of the probe header generator and its bind statement.
`include "l4_probe_header_generator_unit_assert.svh"

module l4phg_checker
   import l4phg_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic [WORD_INDEX_W-1:0] pos_ff;

   // Position of the current beat within its header.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         pos_ff <= rsp_tlast ? '0 : pos_ff + 1'b1;
      end
   end

   `L4PHG_ASSERT_ALWAYS(a_reset_clears_valid, clock, reset |=> !rsp_tvalid)
   `L4PHG_ASSERT(a_stall_holds, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
   `L4PHG_ASSERT(a_last_position, clock, reset,
      (rsp_tvalid && rsp_tlast) |-> (pos_ff == UDP_LAST_INDEX || pos_ff == TCP_LAST_INDEX))
   `L4PHG_ASSERT(a_flags_word, clock, reset,
      (rsp_tvalid && pos_ff == POS_FLAGS) |-> (rsp_tdata == TCP_FLAGS_WORD))

endmodule

bind l4_probe_header_generator_unit l4phg_checker u_l4phg_checker (.*);

>>> dv/l4_probe_header_checker.sv
// Checker that predicts the probe header words and compares the result stream against them.
`timescale 1ns / 100ps

module l4_probe_header_checker
   import l4phg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [15:0]            req_tdata,  // [15:0] remote_port
   input  logic [0:0]             req_tuser,  // [0] action
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [15:0]            rsp_tdata,  // [15:0] header_word
   input  logic                   rsp_tlast,
   output int                     mismatch_count,
   output int                     pending_words
);

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } header_beat_type;

   // Shadow copy of the configuration registers.
   logic                  family_ff;
   logic [CSR_DATA_W-1:0] src_high_ff;
   logic [CSR_DATA_W-1:0] src_low_ff;
   logic [CSR_DATA_W-1:0] tgt_high_ff;
   logic [CSR_DATA_W-1:0] tgt_low_ff;
   logic [WORD_W-1:0]     local_port_ff;

   header_beat_type expected_words[$];
   int              beat_number;

   function automatic int unsigned word_sum(logic [63:0] value);
      return 32'(value[15:0]) + 32'(value[31:16]) + 32'(value[47:32]) + 32'(value[63:48]);
   endfunction

   function automatic logic [WORD_W-1:0] probe_checksum(logic kind, logic [WORD_W-1:0] port);
      int unsigned total;
      total = 32'(local_port_ff) + 32'(port);
      if (kind == KIND_TCP) begin
         total += PROTO_TCP + TCP_LEN + 32'(TCP_FLAGS_WORD) + 32'(TCP_WINDOW);
      end else begin
         total += PROTO_UDP + UDP_LEN + 32'(UDP_LEN_WORD);
      end
      if (family_ff == FAMILY_IPV4) begin
         // Only the low 32 bits of the low address registers take part.
         total += word_sum({32'b0, src_low_ff[31:0]}) + word_sum({32'b0, tgt_low_ff[31:0]});
      end else begin
         total += word_sum(src_high_ff) + word_sum(src_low_ff);
         total += word_sum(tgt_high_ff) + word_sum(tgt_low_ff);
      end
      while ((total >> 16) != 0) begin
         total = (total & 32'hFFFF) + (total >> 16);
      end
      return ~total[WORD_W-1:0];
   endfunction

   task automatic predict_header(logic kind, logic [WORD_W-1:0] port);
      logic [WORD_W-1:0] sum;
      sum = probe_checksum(kind, port);
      expected_words.push_back('{local_port_ff, 1'b0});
      expected_words.push_back('{port, 1'b0});
      if (kind == KIND_TCP) begin
         repeat (4) expected_words.push_back('{16'h0000, 1'b0});
         expected_words.push_back('{TCP_FLAGS_WORD, 1'b0});
         expected_words.push_back('{TCP_WINDOW, 1'b0});
         expected_words.push_back('{sum, 1'b0});
         expected_words.push_back('{16'h0000, 1'b1});
      end else begin
         // A UDP sum of zero goes out as zero.
         expected_words.push_back('{UDP_LEN_WORD, 1'b0});
         expected_words.push_back('{sum, 1'b1});
      end
   endtask

   always @(posedge clock) begin
      header_beat_type head;
      if (reset) begin
         family_ff      <= 1'b0;
         src_high_ff    <= '0;
         src_low_ff     <= '0;
         tgt_high_ff    <= '0;
         tgt_low_ff     <= '0;
         local_port_ff  <= '0;
         expected_words  = {};
         mismatch_count  = 0;
         beat_number     = 0;
         pending_words  <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FAMILY:     family_ff     <= csr_wdata[0];
               CSR_SRC_HIGH:   src_high_ff   <= csr_wdata;
               CSR_SRC_LOW:    src_low_ff    <= csr_wdata;
               CSR_TGT_HIGH:   tgt_high_ff   <= csr_wdata;
               CSR_TGT_LOW:    tgt_low_ff    <= csr_wdata;
               CSR_LOCAL_PORT: local_port_ff <= csr_wdata[WORD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("beat %0d: unexpected word %h last %b", beat_number,
                           rsp_tdata, rsp_tlast);
               end
            end else begin
               head = expected_words.pop_front();
               if (head.word !== rsp_tdata || head.last !== rsp_tlast) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("beat %0d: expected word %h last %b, got word %h last %b",
                              beat_number, head.word, head.last, rsp_tdata, rsp_tlast);
                  end
               end
            end
            beat_number++;
         end
         if (req_tvalid && req_tready) begin
            predict_header(req_tuser[0], req_tdata);
         end
         pending_words <= expected_words.size();
      end
   end

endmodule

>>> dv/testbench.sv
// Top of the probe header generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench
   import l4phg_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 3'd7;
   // With all addresses and the local port at zero, this port makes the UDP sum zero.
   localparam logic [WORD_W-1:0] ZERO_SUM_UDP_PORT = 16'hFFDE;
   localparam logic FAMILY_IPV6 = 1'b1;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata  = '0;  // [15:0] remote_port
   logic [0:0]             req_tuser  = '0;  // [0] action
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;        // [15:0] header_word
   logic                   rsp_tlast;

   int mismatch_count;
   int pending_words;
   int idle_cycles = 0;
   logic tx_steady = 1'b0;
   logic rx_steady = 1'b0;

   always #4 clock = ~clock;

   l4_probe_header_generator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   l4_probe_header_checker probe_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words)
   );

   // Ends the run when no beat and no register write has happened for too long.
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Result side: a random stall before every word, none while rx_steady is set.
   initial begin : rsp_drain
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rx_steady ? 0 : int'($urandom_range(0, 17));
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_probe(logic kind, logic [15:0] port);
      int gap;
      gap = tx_steady ? 0 : int'($urandom_range(0, 17));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= port;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drops valid and waits until every predicted word has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_settings(logic family, logic [63:0] src_high, logic [63:0] src_low,
                                logic [63:0] tgt_high, logic [63:0] tgt_low,
                                logic [15:0] lport);
      logic [63:0] junk;
      junk    = {$urandom, $urandom};
      junk[0] = family;
      write_reg(CSR_FAMILY, junk);
      write_reg(CSR_SRC_HIGH, src_high);
      write_reg(CSR_SRC_LOW, src_low);
      write_reg(CSR_TGT_HIGH, tgt_high);
      write_reg(CSR_TGT_LOW, tgt_low);
      junk       = {$urandom, $urandom};
      junk[15:0] = lport;
      write_reg(CSR_LOCAL_PORT, junk);
      // Writes to indexes past the register list must change nothing.
      write_reg(CSR_UNMAPPED_LO, {$urandom, $urandom});
      write_reg(CSR_UNMAPPED_HI, {$urandom, $urandom});
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] random_address();
      return ($urandom_range(0, 5) == 0) ? '1 : {$urandom, $urandom};
   endfunction

   initial begin
      logic [15:0] port;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers still at their reset values.
      send_probe(KIND_TCP, 16'h0000);
      send_probe(KIND_UDP, 16'h0000);
      send_probe(KIND_TCP, 16'hFFFF);
      send_probe(KIND_UDP, ZERO_SUM_UDP_PORT);
      send_probe(KIND_UDP, 16'hFFFF);
      settle();

      // IPv4 with every address bit set: the upper halves must be ignored.
      load_settings(FAMILY_IPV4, '1, '1, '1, '1, 16'hFFFF);
      send_probe(KIND_TCP, 16'h0000);
      send_probe(KIND_UDP, 16'hFFFF);
      send_probe(KIND_TCP, 16'h8000);
      send_probe(KIND_UDP, 16'h0001);
      settle();

      load_settings(FAMILY_IPV6, '1, '1, '1, '1, 16'h0000);
      send_probe(KIND_TCP, 16'hFFFF);
      send_probe(KIND_UDP, 16'h0000);
      send_probe(KIND_TCP, 16'h1234);
      settle();

      load_settings(FAMILY_IPV6, '0, '0, '0, '0, 16'h0000);
      send_probe(KIND_UDP, ZERO_SUM_UDP_PORT);
      send_probe(KIND_TCP, 16'hFFFF);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         tx_steady = ($urandom_range(0, 2) == 0);
         rx_steady = ($urandom_range(0, 2) == 0);
         load_settings(phase[0], random_address(), random_address(), random_address(),
                       random_address(), 16'($urandom_range(0, 65535)));
         for (int n = 0; n < 55; n++) begin
            if (n == 27) begin
               // Let the block drain mid-phase and change the idling pattern.
               settle();
               tx_steady = ($urandom_range(0, 2) == 0);
               rx_steady = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 4) == 0) begin
               case ($urandom_range(0, 3))
                  0:       port = 16'h0000;
                  1:       port = 16'hFFFF;
                  2:       port = 16'h8000;
                  default: port = 16'h0001;
               endcase
            end else begin
               port = 16'($urandom_range(0, 65535));
            end
            send_probe(1'($urandom_range(0, 1)), port);
         end
         settle();
      end

      if (mismatch_count == 0 && pending_words == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/l4phg_pkg.sv
hw/rtl/l4_probe_header_generator_unit.sv
hw/rtl/l4phg_checker.sv
dv/l4_probe_header_checker.sv
dv/testbench.sv
